[rtl/tsr_pkg.sv]
package tsr_pkg;

	localparam int unsigned MAX_FRAME_BYTES = 2048;
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [15:0] MIN_FRAME_LEN = 16'd54;
	localparam logic [15:0] MAX_FRAME_LEN = 16'(MAX_FRAME_BYTES);
	localparam logic [15:0] MIN_IP_TOTAL = 16'd40;
	localparam logic [16:0] ETH_HDR_LEN = 17'd14;
	localparam logic [7:0] IP_VER_IHL = 8'h45;
	localparam logic [7:0] IP_PROTO_TCP = 8'h06;
	localparam logic [7:0] TCP_DATA_OFFSET = 8'h50;
	localparam logic [7:0] TCP_FLAGS_RST_ACK = 8'h14;
	localparam logic [7:0] TCP_WINDOW_HI = 8'h20;
	localparam logic [2:0] SYN_FLAG_BIT = 3'd1;
	localparam logic [2:0] ACK_FLAG_BIT = 3'd4;
	localparam logic [4:0] REPLY_LAST_IDX = 5'd19;

	// Constant terms of the checksum: protocol, segment length, offset/flags word, window.
	localparam logic [19:0] CSUM_CONST = 20'h00006 + 20'd20 + 20'h05014 + 20'h02000;

	localparam logic REG_LOCAL_ADDRESS = 1'b0;
	localparam logic REG_LOCAL_ADDRESS_VALID = 1'b1;

	typedef struct packed {
		logic [15:0] own_port;
		logic [15:0] peer_port;
		logic [31:0] ack;
		logic [16:0] csum_f1;
		logic [31:0] destination;
	} tsr_reply_t;

	typedef struct packed {
		logic valid;
		tsr_reply_t reply;
	} tsr_push_t;

endpackage

[rtl/tsr_if.sv]
interface tsr_rx_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;
	logic rx_last;

	modport source(output valid, rx_byte, rx_last, input ready);
	modport sink(input valid, rx_byte, rx_last, output ready);
endinterface

interface tsr_tx_if;
	logic valid;
	logic ready;
	logic [7:0] tx_byte;
	logic tx_last;
	logic [31:0] reply_destination;

	modport source(output valid, tx_byte, tx_last, reply_destination, input ready);
	modport sink(input valid, tx_byte, tx_last, reply_destination, output ready);
endinterface

[rtl/tcp_syn_reset_responder.sv]
// Receives an Ethernet frame one beat per byte and answers a TCP SYN addressed to the local
// address with a 20-byte RST+ACK segment, sent one beat per byte with the peer address on
// every beat. The receive side takes a byte in every cycle; it drops ready only when four
// replies are already queued or being prepared, which happens only while the reply side is
// stalled. A reply passes the s1 and s2 registers, the queue and the output register; it is
// sent as 20 beats, and the next reply is loaded from the queue after its last beat.
module tcp_syn_reset_responder (
	input  logic clk,
	input  logic arst_n,
	tsr_rx_if.sink rx,
	tsr_tx_if.source tx,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [31:0] cfg_wdata
);

	tsr_pkg::tsr_push_t push;
	tsr_pkg::tsr_reply_t head;
	logic head_valid;
	logic pop;
	logic [tsr_pkg::QCNT_W-1:0] q_count;

	tsr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.q_count(q_count),
		.push(push)
	);

	tsr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.pop(pop),
		.head_valid(head_valid),
		.head(head),
		.count(q_count)
	);

	tsr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head(head),
		.pop(pop),
		.tx(tx)
	);

	// A reply must never arrive at a full queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> q_count < tsr_pkg::QCNT_W'(tsr_pkg::QDEPTH))
		else $error("reply pushed into a full queue");

	// Taking a reply from the queue without a push leaves its count one lower.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop && head_valid && !push.valid |=> q_count == $past(q_count) - tsr_pkg::QCNT_W'(1))
		else $error("queue count did not drop on pop");

	// The cycle after a reply's last beat leaves, no other last beat is offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && tx.tx_last && tx.ready |=> !tx.valid || !tx.tx_last)
		else $error("two reply ends in consecutive beats");

endmodule

[rtl/tsr_front.sv]
module tsr_front (
	input  logic clk,
	input  logic arst_n,
	tsr_rx_if.sink rx,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic [tsr_pkg::QCNT_W-1:0] q_count,
	output tsr_pkg::tsr_push_t push
);

	logic [31:0] local_address_q;
	logic local_address_valid_q;
	logic [15:0] byte_position_q;
	logic [7:0] version_and_length_q;
	logic [7:0] ip_protocol_q;
	logic [15:0] ip_total_length_q;
	logic [31:0] sender_address_q;
	logic [31:0] target_address_q;
	logic [15:0] sender_port_q;
	logic [15:0] target_port_q;
	logic [31:0] received_sequence_q;
	logic [7:0] received_flags_q;
	logic [31:0] accepted_packet_count_q;

	logic valid_s1;
	logic [15:0] sport_s1, tport_s1;
	logic [31:0] ack_s1, sender_s1, local_s1;
	logic valid_s2;
	logic [15:0] sport_s2, tport_s2;
	logic [31:0] ack_s2, sender_s2;
	logic [17:0] addr_sum_s2, seg_sum_s2;

	logic beat, frame_ok, syn_only;
	logic [15:0] frame_len;
	logic [tsr_pkg::QCNT_W:0] inflight;
	logic [19:0] csum_total;

	assign inflight = {1'b0, q_count} + (tsr_pkg::QCNT_W + 1)'(valid_s1)
		+ (tsr_pkg::QCNT_W + 1)'(valid_s2);
	assign rx.ready = inflight < (tsr_pkg::QCNT_W + 1)'(tsr_pkg::QDEPTH);
	assign beat = rx.valid && rx.ready;

	assign frame_len = (byte_position_q == 16'hFFFF) ? byte_position_q : byte_position_q + 16'd1;

	always_comb begin
		frame_ok = (frame_len >= tsr_pkg::MIN_FRAME_LEN) && (frame_len <= tsr_pkg::MAX_FRAME_LEN)
			&& (version_and_length_q == tsr_pkg::IP_VER_IHL)
			&& (ip_protocol_q == tsr_pkg::IP_PROTO_TCP)
			&& (ip_total_length_q >= tsr_pkg::MIN_IP_TOTAL)
			&& ({1'b0, ip_total_length_q} + tsr_pkg::ETH_HDR_LEN <= {1'b0, frame_len})
			&& local_address_valid_q
			&& (target_address_q == local_address_q);
		syn_only = received_flags_q[tsr_pkg::SYN_FLAG_BIT]
			&& !received_flags_q[tsr_pkg::ACK_FLAG_BIT];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_address_q <= '0;
			local_address_valid_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				tsr_pkg::REG_LOCAL_ADDRESS: local_address_q <= cfg_wdata;
				tsr_pkg::REG_LOCAL_ADDRESS_VALID: local_address_valid_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q <= '0;
			accepted_packet_count_q <= '0;
		end else if (beat) begin
			byte_position_q <= rx.rx_last ? 16'd0 : frame_len;
			if (rx.rx_last && frame_ok) begin
				accepted_packet_count_q <= accepted_packet_count_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (beat) begin
			case (byte_position_q)
				16'd14: version_and_length_q <= rx.rx_byte;
				16'd16: ip_total_length_q[15:8] <= rx.rx_byte;
				16'd17: ip_total_length_q[7:0] <= rx.rx_byte;
				16'd23: ip_protocol_q <= rx.rx_byte;
				16'd26: sender_address_q[31:24] <= rx.rx_byte;
				16'd27: sender_address_q[23:16] <= rx.rx_byte;
				16'd28: sender_address_q[15:8] <= rx.rx_byte;
				16'd29: sender_address_q[7:0] <= rx.rx_byte;
				16'd30: target_address_q[31:24] <= rx.rx_byte;
				16'd31: target_address_q[23:16] <= rx.rx_byte;
				16'd32: target_address_q[15:8] <= rx.rx_byte;
				16'd33: target_address_q[7:0] <= rx.rx_byte;
				16'd34: sender_port_q[15:8] <= rx.rx_byte;
				16'd35: sender_port_q[7:0] <= rx.rx_byte;
				16'd36: target_port_q[15:8] <= rx.rx_byte;
				16'd37: target_port_q[7:0] <= rx.rx_byte;
				16'd38: received_sequence_q[31:24] <= rx.rx_byte;
				16'd39: received_sequence_q[23:16] <= rx.rx_byte;
				16'd40: received_sequence_q[15:8] <= rx.rx_byte;
				16'd41: received_sequence_q[7:0] <= rx.rx_byte;
				16'd47: received_flags_q <= rx.rx_byte;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= beat && rx.rx_last && frame_ok && syn_only;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		sport_s1 <= sender_port_q;
		tport_s1 <= target_port_q;
		ack_s1 <= received_sequence_q + 32'd1;
		sender_s1 <= sender_address_q;
		local_s1 <= local_address_q;

		sport_s2 <= sport_s1;
		tport_s2 <= tport_s1;
		ack_s2 <= ack_s1;
		sender_s2 <= sender_s1;
		addr_sum_s2 <= 18'(local_s1[31:16]) + 18'(local_s1[15:0])
			+ 18'(sender_s1[31:16]) + 18'(sender_s1[15:0]);
		seg_sum_s2 <= 18'(tport_s1) + 18'(sport_s1) + 18'(ack_s1[31:16]) + 18'(ack_s1[15:0]);
	end

	assign csum_total = 20'(addr_sum_s2) + 20'(seg_sum_s2) + tsr_pkg::CSUM_CONST;

	always_comb begin
		push.valid = valid_s2;
		push.reply.own_port = tport_s2;
		push.reply.peer_port = sport_s2;
		push.reply.ack = ack_s2;
		push.reply.csum_f1 = 17'(csum_total[15:0]) + 17'(csum_total[19:16]);
		push.reply.destination = sender_s2;
	end

endmodule

[rtl/tsr_queue.sv]
module tsr_queue (
	input  logic clk,
	input  logic arst_n,
	input  tsr_pkg::tsr_push_t push,
	input  logic pop,
	output logic head_valid,
	output tsr_pkg::tsr_reply_t head,
	output logic [tsr_pkg::QCNT_W-1:0] count
);

	tsr_pkg::tsr_reply_t entries_q [tsr_pkg::QDEPTH];
	logic [tsr_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [tsr_pkg::QCNT_W-1:0] count_q;
	logic do_pop;

	assign do_pop = pop && (count_q != '0);
	assign head_valid = count_q != '0;
	assign head = entries_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entries_q[wr_ptr_q] <= push.reply;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + tsr_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + tsr_pkg::QPTR_W'(1);
			end
			count_q <= count_q + tsr_pkg::QCNT_W'(push.valid) - tsr_pkg::QCNT_W'(do_pop);
		end
	end

endmodule

[rtl/tsr_back.sv]
module tsr_back (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  tsr_pkg::tsr_reply_t head,
	output logic pop,
	tsr_tx_if.source tx
);

	tsr_pkg::tsr_reply_t reply_q;
	logic [15:0] csum_q;
	logic busy_q;
	logic [4:0] idx_q;
	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic out_last_q;
	logic [31:0] out_dest_q;
	logic advance;
	logic [7:0] cur_byte;
	logic [15:0] folded;

	assign pop = !busy_q;
	assign advance = busy_q && (!out_valid_q || tx.ready);
	assign folded = head.csum_f1[15:0] + 16'(head.csum_f1[16]);

	always_comb begin
		case (idx_q)
			5'd0: cur_byte = reply_q.own_port[15:8];
			5'd1: cur_byte = reply_q.own_port[7:0];
			5'd2: cur_byte = reply_q.peer_port[15:8];
			5'd3: cur_byte = reply_q.peer_port[7:0];
			5'd8: cur_byte = reply_q.ack[31:24];
			5'd9: cur_byte = reply_q.ack[23:16];
			5'd10: cur_byte = reply_q.ack[15:8];
			5'd11: cur_byte = reply_q.ack[7:0];
			5'd12: cur_byte = tsr_pkg::TCP_DATA_OFFSET;
			5'd13: cur_byte = tsr_pkg::TCP_FLAGS_RST_ACK;
			5'd14: cur_byte = tsr_pkg::TCP_WINDOW_HI;
			5'd16: cur_byte = csum_q[15:8];
			5'd17: cur_byte = csum_q[7:0];
			default: cur_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		if (!busy_q && head_valid) begin
			reply_q <= head;
			csum_q <= ~folded;
		end
		if (advance) begin
			out_byte_q <= cur_byte;
			out_last_q <= idx_q == tsr_pkg::REPLY_LAST_IDX;
			out_dest_q <= reply_q.destination;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!busy_q) begin
				busy_q <= head_valid;
				idx_q <= '0;
			end else if (advance) begin
				idx_q <= idx_q + 5'd1;
				if (idx_q == tsr_pkg::REPLY_LAST_IDX) begin
					busy_q <= 1'b0;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (tx.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign tx.valid = out_valid_q;
	assign tx.tx_byte = out_byte_q;
	assign tx.tx_last = out_last_q;
	assign tx.reply_destination = out_dest_q;

endmodule
